FILE: hdl/wsc_pkg.sv
// Shared types and constants for the wave sound channel.
// No dependencies; every other file imports this package.
`default_nettype none

package wsc_pkg;

  localparam int unsigned WAVE_ROWS = 4;   // wave RAM held as 4 rows of 4 bytes
  localparam int unsigned ROW_BITS  = 32;

  localparam logic [11:0] DIV_MAX     = 12'd2047;
  localparam logic [8:0]  LENGTH_FULL = 9'd256;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_LEN_CLK  = 3'd1,
    OP_TRIGGER  = 3'd2,
    OP_WAVE_WR  = 3'd3,
    OP_WAVE_RD  = 3'd4,
    OP_LEN_LOAD = 3'd5,
    OP_CLEAR    = 3'd6
  } op_t;

  // Work left for the second stage once the row read has returned
  typedef enum logic [2:0] {
    S1_NONE,
    S1_FETCH,
    S1_CORRUPT,
    S1_WRITE,
    S1_READ,
    S1_CLEAR
  } s1_act_t;

  typedef struct packed {
    op_t        op;
    logic [10:0] period;
    logic        length_enable;
    logic [1:0]  volume_code;
    logic        dac_enable;
    logic [3:0]  wave_index;
    logic [7:0]  wave_data;
    logic [7:0]  length_value;
  } item_t;

  typedef struct packed {
    s1_act_t    act;
    logic [1:0] row;     // row written by a wave write
    logic [1:0] sel;     // byte within the row
    logic       lo_nib;  // fetch takes the low nibble
    logic       single;  // corruption copies one byte only
    logic [7:0] data;
    logic [1:0] vol;
    logic       silent;
    logic       active;
  } s1_t;

  typedef struct packed {
    logic       en;
    logic [1:0] row;
  } mem_rd_t;

  typedef struct packed {
    logic                en;
    logic [1:0]          row;
    logic [ROW_BITS-1:0] data;
  } mem_wr_t;

  function automatic logic [7:0] row_byte(input logic [ROW_BITS-1:0] r,
                                          input logic [1:0] sel);
    row_byte = r[{sel, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/wsc_wave_mem.sv
// Wave RAM: 4 x 32-bit rows, registered read, one write port.
// Row valid bits stand in for the reset clear; depends on wsc_pkg.
`default_nettype none

module wsc_wave_mem
  import wsc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mem_rd_t             rd,
  input  wire mem_wr_t             wr,
  output logic [ROW_BITS-1:0]      rd_data
);

  logic [ROW_BITS-1:0] mem_r [WAVE_ROWS];
  logic [WAVE_ROWS-1:0] row_valid_r;
  logic [ROW_BITS-1:0] rd_q_r;
  logic                rd_valid_r;
  logic                fwd_hit_r;
  logic [ROW_BITS-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.row] <= wr.data;
    end
    if (rd.en) begin
      rd_q_r <= mem_r[rd.row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr.en) begin
      row_valid_r[wr.row] <= 1'b1;
    end
  end

  // A write landing on the row being read at the same edge is forwarded
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_valid_r <= row_valid_r[rd.row];
      fwd_hit_r  <= wr.en && (wr.row == rd.row);
      fwd_data_r <= wr.data;
    end
  end

  assign rd_data = fwd_hit_r  ? fwd_data_r :
                   rd_valid_r ? rd_q_r     : '0;

endmodule

`default_nettype wire

FILE: hdl/wsc_ctrl.sv
// Front stage: scalar channel state (position, divider, length, active).
// Decodes each transfer and issues the wave RAM row read; depends on wsc_pkg.
`default_nettype none

module wsc_ctrl
  import wsc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  accept,
  input  wire item_t item,
  output mem_rd_t    rd,
  output s1_t        s1_nxt
);

  logic [4:0]  position_r, position_nxt;
  logic [11:0] divider_r, divider_nxt;
  logic [10:0] reload_r, reload_nxt;
  logic [3:0]  lfb_r, lfb_nxt;
  logic [8:0]  len_r, len_nxt;
  logic        active_r, active_nxt;
  logic [11:0] div_inc;
  mem_rd_t     rd_req;

  always_comb begin
    position_nxt = position_r;
    divider_nxt  = divider_r;
    reload_nxt   = reload_r;
    lfb_nxt      = lfb_r;
    len_nxt      = len_r;
    active_nxt   = active_r;
    div_inc      = divider_r + 12'd1;
    rd_req       = '{en: 1'b0, row: 2'd0};
    s1_nxt       = '{act: S1_NONE, row: 2'd0, sel: 2'd0, lo_nib: 1'b0, single: 1'b0,
                     data: item.wave_data, vol: item.volume_code,
                     silent: 1'b1, active: 1'b0};

    unique case (item.op)
      OP_TICK: begin
        if (active_r && item.dac_enable) begin
          divider_nxt = div_inc;
          if (div_inc > DIV_MAX) begin
            rd_req        = '{en: 1'b1, row: position_r[4:3]};
            s1_nxt.act    = S1_FETCH;
            s1_nxt.sel    = position_r[2:1];
            s1_nxt.lo_nib = position_r[0];
            lfb_nxt       = position_r[4:1];
            position_nxt  = position_r + 5'd1;
            reload_nxt    = item.period;
            divider_nxt   = {1'b0, item.period};
          end
        end
      end
      OP_LEN_CLK: begin
        if (item.length_enable && (len_r != 9'd0)) begin
          len_nxt = len_r - 9'd1;
          if (len_r == 9'd1) begin
            active_nxt = 1'b0;
          end
        end
      end
      OP_TRIGGER: begin
        if (len_r == 9'd0) begin
          len_nxt = LENGTH_FULL;
        end
        // corruption: copy the last fetched byte (or its group of four) to the front
        if (active_r && (divider_r <= {1'b0, reload_r})) begin
          rd_req        = '{en: 1'b1, row: lfb_r[3:2]};
          s1_nxt.act    = S1_CORRUPT;
          s1_nxt.sel    = lfb_r[1:0];
          s1_nxt.single = (lfb_r[3:2] == 2'd0);
        end
        reload_nxt   = item.period;
        divider_nxt  = {1'b0, item.period};
        position_nxt = 5'd0;
        if (item.dac_enable) begin
          active_nxt = 1'b1;
        end
      end
      OP_WAVE_WR: begin
        rd_req     = '{en: 1'b1, row: item.wave_index[3:2]};
        s1_nxt.act = S1_WRITE;
        s1_nxt.row = item.wave_index[3:2];
        s1_nxt.sel = item.wave_index[1:0];
      end
      OP_WAVE_RD: begin
        rd_req     = '{en: 1'b1, row: item.wave_index[3:2]};
        s1_nxt.act = S1_READ;
        s1_nxt.sel = item.wave_index[1:0];
      end
      OP_LEN_LOAD: begin
        len_nxt = LENGTH_FULL - {1'b0, item.length_value};
      end
      OP_CLEAR: begin
        position_nxt = 5'd0;
        divider_nxt  = 12'd0;
        reload_nxt   = 11'd0;
        s1_nxt.act   = S1_CLEAR;
      end
      default: begin
      end
    endcase

    s1_nxt.active = active_nxt;
    s1_nxt.silent = !active_nxt || !item.dac_enable;
    rd            = '{en: rd_req.en && accept, row: rd_req.row};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= 5'd0;
      divider_r  <= 12'd0;
      reload_r   <= 11'd0;
      lfb_r      <= 4'd0;
      len_r      <= 9'd0;
      active_r   <= 1'b0;
    end else if (accept) begin
      position_r <= position_nxt;
      divider_r  <= divider_nxt;
      reload_r   <= reload_nxt;
      lfb_r      <= lfb_nxt;
      len_r      <= len_nxt;
      active_r   <= active_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_trigger_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (item.op == OP_TRIGGER) |=> (len_r != 9'd0))
    else $error("length counter zero after trigger");

  a_divider_range: assert property (@(posedge clk) disable iff (!rst_n)
    divider_r <= DIV_MAX)
    else $error("divider left above period limit");
`endif

endmodule

`default_nettype wire

FILE: hdl/wsc_result.sv
// Back stage: completes wave RAM read-modify-write, nibble fetch and result.
// Holds the output register; depends on wsc_pkg.
`default_nettype none

module wsc_result
  import wsc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire s1_t                 s1_nxt,
  input  wire logic [ROW_BITS-1:0] rd_data,
  input  wire logic                out_ready,
  output logic                     in_ready,
  output mem_wr_t                  wr,
  output logic                     out_valid,
  output logic [3:0]               sample,
  output logic                     silent,
  output logic                     channel_on,
  output logic [7:0]               read_data
);

  logic       s1_valid_r;
  s1_t        s1_r;
  logic [3:0] nib_r, nib_nxt;
  logic       out_valid_r;
  logic [3:0] sample_r, sample_nxt;
  logic       silent_r;
  logic       chon_r;
  logic [7:0] rdata_r, rdata_nxt;
  logic [7:0] sel_byte;
  logic       advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    sel_byte  = row_byte(rd_data, s1_r.sel);
    nib_nxt   = nib_r;
    rdata_nxt = 8'd0;
    wr        = '{en: 1'b0, row: 2'd0, data: rd_data};

    unique case (s1_r.act)
      S1_FETCH: begin
        nib_nxt = s1_r.lo_nib ? sel_byte[3:0] : sel_byte[7:4];
      end
      S1_CORRUPT: begin
        wr.en  = advance;
        wr.row = 2'd0;
        wr.data = s1_r.single ? {rd_data[ROW_BITS-1:8], sel_byte} : rd_data;
      end
      S1_WRITE: begin
        wr.en  = advance;
        wr.row = s1_r.row;
        for (int k = 0; k < 4; k++) begin
          if (2'(k) == s1_r.sel) begin
            wr.data[k*8 +: 8] = s1_r.data;
          end
        end
      end
      S1_READ: begin
        rdata_nxt = sel_byte;
      end
      S1_CLEAR: begin
        nib_nxt = 4'd0;
      end
      default: begin
      end
    endcase

    sample_nxt = 4'd0;
    if (!s1_r.silent) begin
      case (s1_r.vol)
        2'd1:    sample_nxt = nib_nxt;
        2'd2:    sample_nxt = nib_nxt >> 1;
        2'd3:    sample_nxt = nib_nxt >> 2;
        default: sample_nxt = 4'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      nib_r       <= 4'd0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        nib_r       <= nib_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (advance) begin
      sample_r <= sample_nxt;
      silent_r <= s1_r.silent;
      chon_r   <= s1_r.active;
      rdata_r  <= rdata_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign sample     = sample_r;
  assign silent     = silent_r;
  assign channel_on = chon_r;
  assign read_data  = rdata_r;

`ifndef ASSERT_OFF
  a_read_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_r.act != S1_READ) |=> (rdata_r == 8'd0))
    else $error("wave read data on a non-read result");

  a_silent_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && silent_r |-> (sample_r == 4'd0))
    else $error("sample non-zero while silent");
`endif

endmodule

`default_nettype wire

FILE: hdl/wave_sound_channel_top.sv
// Top level of the wave sound channel: stream ports, front and back stages.
// Instantiates wsc_ctrl, wsc_wave_mem and wsc_result; depends on wsc_pkg.
//
//  channel | dir | tdata                          | tuser
//  --------+-----+--------------------------------+-----------
//  in_     | in  | 40b: period..length_value      | operation
//  out_    | out | 16b: sample, channel_on, rdata | silent
//
// One transfer per clock while the output drains; a result passes the row read
// register, then the output one (row read returns, back stage writes back).
// The registered read of the 4-row wave RAM is what sets the
// pipeline depth; a write-back to the row read at the same edge is forwarded.
// Reset clears four row valid bits: no clearing pass, ready straight away.
// in_tready follows out_tready through the back stage when the output is full.
`default_nettype none

module wave_sound_channel_top
  import wsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [10:0] period, [11] length_enable, [13:12] volume_code, [14] dac_enable,
  // [18:15] wave_index, [26:19] wave_data, [34:27] length_value, [39:35] zero
  input  wire logic [39:0] in_tdata,
  // [2:0] operation
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] sample, [4] channel_on, [12:5] wave_read_data, [15:13] zero
  output logic [15:0]      out_tdata,
  // [0] silent
  output logic             out_tuser
);

  item_t                item;
  logic                 accept;
  mem_rd_t              rd;
  mem_wr_t              wr;
  s1_t                  s1_nxt;
  logic [ROW_BITS-1:0]  rd_data;
  logic [3:0]           sample;
  logic                 channel_on;
  logic [7:0]           read_data;

  assign item = '{op:            op_t'(in_tuser),
                  period:        in_tdata[10:0],
                  length_enable: in_tdata[11],
                  volume_code:   in_tdata[13:12],
                  dac_enable:    in_tdata[14],
                  wave_index:    in_tdata[18:15],
                  wave_data:     in_tdata[26:19],
                  length_value:  in_tdata[34:27]};

  // input transfer
  assign accept = in_tvalid && in_tready;

  wsc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .rd     (rd),
    .s1_nxt (s1_nxt)
  );

  wsc_wave_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data)
  );

  wsc_result u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .s1_nxt     (s1_nxt),
    .rd_data    (rd_data),
    .out_ready  (out_tready),
    .in_ready   (in_tready),
    .wr         (wr),
    .out_valid  (out_tvalid),
    .sample     (sample),
    .silent     (out_tuser),
    .channel_on (channel_on),
    .read_data  (read_data)
  );

  assign out_tdata = {3'b000, read_data, channel_on, sample};

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the wave sound channel: directed table, then random notes.
// Drives wave_sound_channel_top's stream ports and checks every result against a typed
// answer or a behavioural channel copy; depends on wsc_pkg for op codes and limits.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wsc_pkg::*;

  // Code 7 has no meaning; the block must still answer it.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int ITEMS_PER_PHASE = 135;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 300000;

  typedef struct packed {
    logic [2:0]  op;
    logic [10:0] period;
    logic        len_en;
    logic [1:0]  vol;
    logic        dac;
    logic [3:0]  idx;
    logic [7:0]  data;
    logic [7:0]  lval;
  } sound_cmd_t;

  typedef struct packed {
    logic [3:0] sample;
    logic       silent;
    logic       on;
    logic [7:0] rdata;
  } chan_out_t;

  typedef struct packed {
    sound_cmd_t cmd;
    logic       typed;   // 1: want below is the answer, not the channel copy
    chan_out_t  want;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;

  wave_sound_channel_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Channel copy: wave RAM, nibble position, divider, length counter.
  logic [7:0]  wave_copy [16];
  logic [4:0]  pos_q;
  logic [11:0] div_q;
  logic [10:0] reload_q;
  logic [3:0]  nib_q;
  logic [3:0]  last_byte_q;
  logic [8:0]  len_q;
  logic        on_q;

  chan_out_t  outputs_due[$];
  table_row_t directed_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int failures;
  int transfers_in;
  int n_fetch;
  int n_copy;
  int n_expire;
  int cycle_count;

  // One item through the channel copy; returns what the block should send back.
  function automatic chan_out_t advance_channel(input sound_cmd_t c);
    chan_out_t  r;
    logic [7:0] b;
    logic [3:0] base;
    r = '0;
    case (c.op)
      OP_TICK: begin
        if (on_q && c.dac) begin
          div_q = div_q + 12'd1;
          if (div_q > DIV_MAX) begin
            b           = wave_copy[pos_q[4:1]];
            nib_q       = pos_q[0] ? b[3:0] : b[7:4];
            last_byte_q = pos_q[4:1];
            pos_q       = pos_q + 5'd1;
            reload_q    = c.period;
            div_q       = {1'b0, c.period};
            n_fetch++;
          end
        end
      end
      OP_LEN_CLK: begin
        if (c.len_en && len_q != 9'd0) begin
          len_q = len_q - 9'd1;
          if (len_q == 9'd0) begin
            on_q = 1'b0;
            n_expire++;
          end
        end
      end
      OP_TRIGGER: begin
        if (len_q == 9'd0) len_q = LENGTH_FULL;
        // retrigger while the divider sits at its reload value scrambles the RAM head
        if (on_q && div_q <= {1'b0, reload_q}) begin
          n_copy++;
          if (last_byte_q < 4'd4) begin
            wave_copy[0] = wave_copy[last_byte_q];
          end else begin
            base = last_byte_q & 4'hC;
            for (int i = 0; i < 4; i++) wave_copy[4'(i)] = wave_copy[base + 4'(i)];
          end
        end
        reload_q = c.period;
        div_q    = {1'b0, c.period};
        pos_q    = '0;
        if (c.dac) on_q = 1'b1;
      end
      OP_WAVE_WR:  wave_copy[c.idx] = c.data;
      OP_WAVE_RD:  r.rdata = wave_copy[c.idx];
      OP_LEN_LOAD: len_q = LENGTH_FULL - {1'b0, c.lval};
      OP_CLEAR: begin
        nib_q    = '0;
        pos_q    = '0;
        div_q    = '0;
        reload_q = '0;
      end
      default: ;
    endcase
    r.silent = !on_q || !c.dac;
    if (!r.silent && c.vol != 2'd0) r.sample = nib_q >> (c.vol - 1);
    r.on = on_q;
    return r;
  endfunction

  function automatic sound_cmd_t mk_cmd(input logic [2:0] op, input logic [10:0] period,
                                        input logic len_en, input logic [1:0] vol,
                                        input logic dac, input logic [3:0] idx,
                                        input logic [7:0] data, input logic [7:0] lval);
    sound_cmd_t c;
    c.op = op; c.period = period; c.len_en = len_en; c.vol = vol;
    c.dac = dac; c.idx = idx; c.data = data; c.lval = lval;
    return c;
  endfunction

  function automatic chan_out_t mk_out(input logic [3:0] sample, input logic silent,
                                       input logic on, input logic [7:0] rdata);
    chan_out_t r;
    r.sample = sample; r.silent = silent; r.on = on; r.rdata = rdata;
    return r;
  endfunction

  function automatic sound_cmd_t rand_cmd();
    sound_cmd_t c;
    c.op     = 3'($urandom_range(7));
    c.period = 11'($urandom);
    c.len_en = 1'($urandom);
    c.vol    = 2'($urandom);
    c.dac    = 1'($urandom);
    c.idx    = 4'($urandom);
    c.data   = 8'($urandom);
    c.lval   = 8'($urandom);
    return c;
  endfunction

  // Offer one item, maybe after an idle gap, and book its result once it is taken.
  task automatic offer(input sound_cmd_t c, input logic typed, input chan_out_t want);
    chan_out_t due;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, c.lval, c.data, c.idx, c.dac, c.vol, c.len_en, c.period};
    in_tuser  <= c.op;
    do @(posedge clk); while (!in_tready);
    due = advance_channel(c);
    outputs_due.push_back(typed ? want : due);
    transfers_in++;
  endtask

  // Mostly well-formed notes (fill RAM, set length, trigger, run the divider),
  // with one draw in five a single item of pure noise.
  task automatic random_stretch(input int n);
    sound_cmd_t  c;
    int          made;
    int          steps;
    int          pick;
    logic [10:0] per;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) < 2) begin
        offer(rand_cmd(), 1'b0, '0);
        made++;
      end else begin
        // high periods fetch every tick or nearly; a few low ones barely move
        per = 11'(($urandom_range(5) == 0) ? $urandom_range(2047)
                                            : $urandom_range(2047, 2036));
        repeat ($urandom_range(3)) begin
          c    = rand_cmd();
          c.op = OP_WAVE_WR;
          offer(c, 1'b0, '0);
          made++;
        end
        c    = rand_cmd();
        c.op = OP_LEN_LOAD;
        if ($urandom_range(1)) c.lval = 8'($urandom_range(255, 248));
        offer(c, 1'b0, '0);
        made++;
        c        = rand_cmd();
        c.op     = OP_TRIGGER;
        c.period = per;
        c.dac    = ($urandom_range(7) != 0);
        offer(c, 1'b0, '0);
        made++;
        steps = $urandom_range(40, 4);
        repeat (steps) begin
          c        = rand_cmd();
          c.period = per;
          c.dac    = ($urandom_range(15) != 0);
          pick     = $urandom_range(99);
          if (pick < 70)      c.op = OP_TICK;
          else if (pick < 82) c.op = OP_LEN_CLK;
          else if (pick < 88) c.op = OP_WAVE_RD;
          else if (pick < 92) c.op = OP_TRIGGER;
          else if (pick < 95) c.op = OP_WAVE_WR;
          else if (pick < 98) c.op = OP_LEN_LOAD;
          else                c.op = OP_CLEAR;
          offer(c, 1'b0, '0);
          made++;
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Runaway guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request so the
  // pipeline fills and in_tready must drop.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every result transfer is matched with the oldest outstanding one.
  always @(posedge clk) begin : check_results
    chan_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (outputs_due.size() == 0) begin
        $error("result transfer with nothing outstanding: tdata %h tuser %b",
               out_tdata, out_tuser);
        failures++;
      end else begin
        want = outputs_due.pop_front();
        if (out_tdata[3:0] !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, out_tdata[3:0]);
          failures++;
        end
        if (out_tuser !== want.silent) begin
          $error("silent: expected %0b, got %0b", want.silent, out_tuser);
          failures++;
        end
        if (out_tdata[4] !== want.on) begin
          $error("channel_on: expected %0b, got %0b", want.on, out_tdata[4]);
          failures++;
        end
        if (out_tdata[12:5] !== want.rdata) begin
          $error("wave_read_data: expected %h, got %h", want.rdata, out_tdata[12:5]);
          failures++;
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    hold_req   = 1'b0;
    failures   = 0;
    cycle_count = 0;
    for (int i = 0; i < 16; i++) wave_copy[i] = '0;
    pos_q = '0; div_q = '0; reload_q = '0; nib_q = '0;
    last_byte_q = '0; len_q = '0; on_q = 1'b0;

    // Directed table. Typed answers only where obvious: after reset, silent
    // cases, full-scale nibble, length expiry. The rest go through the copy.
    directed_rows.push_back({mk_cmd(OP_WAVE_RD, 0, 0, 0, 0, 15, 0, 0), 1'b1,
                             mk_out(0, 1, 0, 8'h00)});
    directed_rows.push_back({mk_cmd(OP_WAVE_WR, 0, 0, 0, 0, 0, 8'hFF, 0), 1'b1,
                             mk_out(0, 1, 0, 8'h00)});
    directed_rows.push_back({mk_cmd(OP_WAVE_WR, 0, 0, 0, 0, 15, 8'h00, 0), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_WAVE_WR, 0, 0, 0, 0, 1, 8'hA5, 0), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_WAVE_RD, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_out(0, 1, 0, 8'hFF)});
    // tick on an idle channel does nothing
    directed_rows.push_back({mk_cmd(OP_TICK, 2047, 0, 1, 1, 0, 0, 0), 1'b1,
                             mk_out(0, 1, 0, 8'h00)});
    directed_rows.push_back({mk_cmd(OP_TRIGGER, 2047, 0, 1, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    // period 2047: every tick fetches; first nibble is the high half of byte 0
    directed_rows.push_back({mk_cmd(OP_TICK, 2047, 0, 1, 1, 0, 0, 0), 1'b1,
                             mk_out(15, 0, 1, 8'h00)});
    directed_rows.push_back({mk_cmd(OP_TICK, 2047, 0, 2, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_TICK, 2047, 0, 3, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_TICK, 2047, 0, 0, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    // retrigger right after a fetch: single-byte RAM copy into byte 0
    directed_rows.push_back({mk_cmd(OP_TRIGGER, 2047, 0, 1, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_WAVE_RD, 2047, 0, 1, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_LEN_LOAD, 0, 0, 1, 1, 0, 0, 255), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_LEN_CLK, 0, 0, 1, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    // counter of one runs out: channel switches off
    directed_rows.push_back({mk_cmd(OP_LEN_CLK, 0, 1, 1, 1, 0, 0, 0), 1'b1,
                             mk_out(0, 1, 0, 8'h00)});
    // trigger with the DAC off leaves the channel off
    directed_rows.push_back({mk_cmd(OP_TRIGGER, 0, 0, 1, 0, 0, 0, 0), 1'b1,
                             mk_out(0, 1, 0, 8'h00)});
    directed_rows.push_back({mk_cmd(OP_LEN_LOAD, 0, 0, 1, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_TRIGGER, 0, 0, 1, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    // on but DAC off: silent, still reported on
    directed_rows.push_back({mk_cmd(OP_TICK, 0, 0, 1, 0, 0, 0, 0), 1'b1,
                             mk_out(0, 1, 1, 8'h00)});
    directed_rows.push_back({mk_cmd(OP_TICK, 0, 0, 1, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_CLEAR, 0, 0, 1, 1, 0, 0, 0), 1'b0, chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_UNUSED, 2047, 1, 3, 1, 15, 8'hFF, 255), 1'b0,
                             chan_out_t'(0)});
    directed_rows.push_back({mk_cmd(OP_WAVE_RD, 0, 0, 1, 1, 15, 0, 0), 1'b0, chan_out_t'(0)});

    // phase one: sender rarely idles, receiver mostly stalls
    send_idle_pct  = 8;
    recv_stall_pct = 87;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) offer(directed_rows[i].cmd, directed_rows[i].typed,
                                     directed_rows[i].want);
    random_stretch(ITEMS_PER_PHASE);

    // phase two: the other way round
    send_idle_pct  = 87;
    recv_stall_pct = 8;
    random_stretch(ITEMS_PER_PHASE);

    // phase three: no idling, and one long hold-off on the result side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    random_stretch(ITEMS_PER_PHASE);

    in_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d transfers in, %0d nibble fetches, %0d wave RAM copies on retrigger,",
             transfers_in, n_fetch, n_copy);
    $display("     %0d length expiries, %0d check failures", n_expire, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
